### hdl/lms_pkg.sv
// shared types, register map and level helpers for the led matrix grayscale scanner
// depends on nothing; imported by lms_frame_store, led_matrix_grayscale_scanner and the testbench files
package lms_pkg;

  typedef struct packed {
    logic       command;
    logic [2:0] column;
    logic [2:0] row;
    logic [1:0] colour;
  } in_cmd_t;

  typedef struct packed {
    logic [2:0] row_index;
    logic [7:0] anode_select;
    logic [7:0] cathode_bits;
  } out_res_t;

  // commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // level codes
  localparam logic [1:0] LVL_OFF   = 2'd0;
  localparam logic [1:0] LVL_DARK  = 2'd1;
  localparam logic [1:0] LVL_LIGHT = 2'd2;
  localparam logic [1:0] LVL_FULL  = 2'd3;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_DIVIDER   = 3'd0;
  localparam logic [2:0] REG_LIGHT_ON  = 3'd1;
  localparam logic [2:0] REG_LIGHT_OFF = 3'd2;
  localparam logic [2:0] REG_DARK_ON   = 3'd3;
  localparam logic [2:0] REG_DARK_OFF  = 3'd4;

  localparam logic [15:0] RST_DIVIDER   = 16'd1;
  localparam logic [3:0]  RST_LIGHT_ON  = 4'd3;
  localparam logic [3:0]  RST_LIGHT_OFF = 4'd1;
  localparam logic [3:0]  RST_DARK_ON   = 4'd1;
  localparam logic [3:0]  RST_DARK_OFF  = 4'd3;
  localparam logic [7:0]  ANODE_FIRST   = 8'h80;

  // phase counter step: wraps at on+off (saturated to 15), or modulo 16
  function automatic logic [3:0] next_phase(input logic [3:0] ph, input logic [3:0] on,
                                            input logic [3:0] off);
    logic [4:0] sum;
    logic [3:0] per;
    logic [3:0] inc;
    sum = {1'b0, on} + {1'b0, off};
    per = (sum > 5'd15) ? 4'd15 : sum[3:0];
    inc = ph + 4'd1;
    return (inc == per) ? 4'd0 : inc;
  endfunction

  function automatic logic pixel_lit(input logic [1:0] code,
                                     input logic [3:0] light_ph, input logic [3:0] light_on,
                                     input logic [3:0] dark_ph, input logic [3:0] dark_on);
    logic lit;
    case (code)
      LVL_FULL:  lit = 1'b1;
      LVL_LIGHT: lit = light_ph < light_on;
      LVL_DARK:  lit = dark_ph < dark_on;
      default:   lit = 1'b0;
    endcase
    return lit;
  endfunction

endpackage

### hdl/lms_frame_store.sv
// frame store: one word of 2-bit pixel codes per row, synchronous read
// rows never written since reset read as all off through per-row valid bits; uses lms_pkg
module lms_frame_store #(
  parameter int ROWS = 8,
  parameter int LW   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    rd_en,
  input  logic [$clog2(ROWS)-1:0] rd_addr,
  output logic [LW-1:0]           rd_data,
  input  logic                    wr_en,
  input  logic [$clog2(ROWS)-1:0] wr_addr,
  input  logic [LW-1:0]           wr_data
);
  import lms_pkg::*;

  logic [LW-1:0]   mem [ROWS];
  logic [ROWS-1:0] vld_r;
  logic [LW-1:0]   rd_data_r;
  logic            rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### hdl/led_matrix_grayscale_scanner.sv
// led matrix row scanner with four gray levels; top level with register port and control
// depends on lms_pkg and lms_frame_store
//
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+----------------------------------
//  input    | start, busy, in_cmd                 | beat taken when start & !busy
//  result   | out_strobe, out_res                 | beat shown for one cycle, no stall
//  config   | psel penable pwrite paddr pwdata    | write when psel&penable&pwrite
//           | prdata pready                       | pready tied high
//
// a tick that does not fire leaves the block idle; a pixel write and a firing tick enter a
// busy state (ST_WR or ST_TK), as each first reads its row from the frame store read port.
// a row result is registered from the row read in ST_TK; the next item may enter as it is shown.
// reset clears counters and per-row valid bits at once; there is no clearing pass.
// the result side cannot stall, so busy only follows the frame store access.
module led_matrix_grayscale_scanner #(
  parameter int ROWS    = 8,
  parameter int COLUMNS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lms_pkg::in_cmd_t  in_cmd,
  output logic              out_strobe,
  output lms_pkg::out_res_t out_res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import lms_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int RCW   = $clog2(ROWS + 1);
  localparam int LW    = 2 * COLUMNS;
  localparam int NCATH = (COLUMNS < 8) ? COLUMNS : 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WR   = 2'd1;
  localparam logic [1:0] ST_TK   = 2'd2;

  // configuration registers
  logic [15:0] div_r;
  logic [3:0]  light_on_r, light_off_r, dark_on_r, dark_off_r;

  logic [1:0]     state_r, state_nxt;
  logic [15:0]    tick_r, tick_nxt;
  logic [RCW-1:0] row_count_r, row_count_nxt;
  logic [7:0]     sel_r, sel_nxt;
  logic [7:0]     phase_r, phase_nxt;
  logic [2:0]     pend_idx_r, pend_idx_nxt;
  logic [7:0]     pend_anode_r, pend_anode_nxt;
  logic [RW-1:0]  wr_row_r, wr_row_nxt;
  logic [2:0]     wr_col_r, wr_col_nxt;
  logic [1:0]     wr_colour_r, wr_colour_nxt;
  logic           out_strobe_r, out_strobe_nxt;
  out_res_t       out_res_r, out_res_nxt;

  logic           accept;
  logic [15:0]    tick_inc;
  logic           fire;
  logic           wrap;
  logic [RCW-1:0] cur_row;
  logic [7:0]     cur_sel;
  logic [31:0]    cur_row_ext;
  logic [31:0]    in_row_ext;
  logic [31:0]    in_col_ext;
  logic           in_pix_ok;

  logic           rd_en;
  logic [RW-1:0]  rd_addr;
  logic [LW-1:0]  rd_data;
  logic           wr_en;
  logic [LW-1:0]  merged;
  logic [7:0]     cath;

  // config port
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r       <= RST_DIVIDER;
      light_on_r  <= RST_LIGHT_ON;
      light_off_r <= RST_LIGHT_OFF;
      dark_on_r   <= RST_DARK_ON;
      dark_off_r  <= RST_DARK_OFF;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DIVIDER:   div_r       <= pwdata[15:0];
        REG_LIGHT_ON:  light_on_r  <= pwdata[3:0];
        REG_LIGHT_OFF: light_off_r <= pwdata[3:0];
        REG_DARK_ON:   dark_on_r   <= pwdata[3:0];
        REG_DARK_OFF:  dark_off_r  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DIVIDER:   prdata = {16'd0, div_r};
      REG_LIGHT_ON:  prdata = {28'd0, light_on_r};
      REG_LIGHT_OFF: prdata = {28'd0, light_off_r};
      REG_DARK_ON:   prdata = {28'd0, dark_on_r};
      REG_DARK_OFF:  prdata = {28'd0, dark_off_r};
      default:       prdata = '0;
    endcase
  end

  // item decode
  assign busy        = (state_r != ST_IDLE);
  assign accept      = start & ~busy;
  assign tick_inc    = tick_r + 16'd1;
  assign fire        = (tick_inc >= div_r);
  assign wrap        = (32'(row_count_r) >= ROWS);
  assign cur_row     = wrap ? '0 : row_count_r;
  assign cur_sel     = wrap ? ANODE_FIRST : sel_r;
  assign cur_row_ext = 32'(cur_row);
  assign in_row_ext  = 32'(in_cmd.row);
  assign in_col_ext  = 32'(in_cmd.column);
  assign in_pix_ok   = (in_row_ext < ROWS) && (in_col_ext < COLUMNS);

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    row_count_nxt  = row_count_r;
    sel_nxt        = sel_r;
    phase_nxt      = phase_r;
    pend_idx_nxt   = pend_idx_r;
    pend_anode_nxt = pend_anode_r;
    wr_row_nxt     = wr_row_r;
    wr_col_nxt     = wr_col_r;
    wr_colour_nxt  = wr_colour_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    rd_en          = 1'b0;
    rd_addr        = cur_row[RW-1:0];
    wr_en          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd.command == CMD_TICK) begin
            tick_nxt = fire ? 16'd0 : tick_inc;
            if (fire) begin
              if (wrap) begin
                phase_nxt = {next_phase(phase_r[7:4], light_on_r, light_off_r),
                             next_phase(phase_r[3:0], dark_on_r, dark_off_r)};
              end
              row_count_nxt  = cur_row + RCW'(1);
              sel_nxt        = cur_sel >> 1;
              pend_idx_nxt   = cur_row_ext[2:0];
              pend_anode_nxt = cur_sel;
              rd_en          = 1'b1;
              rd_addr        = cur_row[RW-1:0];
              state_nxt      = ST_TK;
            end
          end else if (in_pix_ok) begin
            // fetch the row, merge the pixel next cycle
            wr_row_nxt    = in_row_ext[RW-1:0];
            wr_col_nxt    = in_cmd.column;
            wr_colour_nxt = in_cmd.colour;
            rd_en         = 1'b1;
            rd_addr       = in_row_ext[RW-1:0];
            state_nxt     = ST_WR;
          end
        end
      end
      ST_WR: begin
        wr_en     = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_TK: begin
        out_strobe_nxt           = 1'b1;
        out_res_nxt.row_index    = pend_idx_r;
        out_res_nxt.anode_select = pend_anode_r;
        out_res_nxt.cathode_bits = cath;
        state_nxt                = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // pixel merge for the write-back
  always_comb begin
    merged = rd_data;
    for (int c = 0; c < COLUMNS; c++) begin
      if (32'(wr_col_r) == c) begin
        merged[2*(COLUMNS-1-c) +: 2] = wr_colour_r;
      end
    end
  end

  // cathode pattern of the fetched row
  for (genvar c = 0; c < 8; c++) begin : g_cath
    if (c < NCATH) begin : g_on
      assign cath[c] = pixel_lit(rd_data[2*(COLUMNS-1-c) +: 2], phase_r[7:4], light_on_r,
                                 phase_r[3:0], dark_on_r);
    end else begin : g_off
      assign cath[c] = 1'b0;
    end
  end

  lms_frame_store #(
    .ROWS (ROWS),
    .LW   (LW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_row_r),
    .wr_data (merged)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_r       <= '0;
      row_count_r  <= RCW'(ROWS);
      sel_r        <= ANODE_FIRST;
      phase_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_r       <= tick_nxt;
      row_count_r  <= row_count_nxt;
      sel_r        <= sel_nxt;
      phase_r      <= phase_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    pend_anode_r <= pend_anode_nxt;
    wr_row_r     <= wr_row_nxt;
    wr_col_r     <= wr_col_nxt;
    wr_colour_r  <= wr_colour_nxt;
    out_res_r    <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  // a result beat only follows a row fetch
  a_strobe_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == ST_TK))
    else $error("result beat without a row fetch");

  // write-back and row output states are always left for idle in the following cycle
  a_single_cycle_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR || state_r == ST_TK) |=> (state_r == ST_IDLE))
    else $error("busy state held longer than one cycle");

  a_anode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $onehot0(out_res_r.anode_select))
    else $error("anode select not one-hot");

  a_row_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_count_r) <= ROWS)
    else $error("row counter out of range");

  // a tick that fires always lands on a fetch
  a_fire_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd.command == CMD_TICK && fire) |=> (state_r == ST_TK))
    else $error("firing tick did not fetch a row");

endmodule

### tb/lms_scan_checker.sv
// row-scan checker for led_matrix_grayscale_scanner: predicts every row beat from the
// accepted commands and register writes, and compares it with the result channel
// depends on lms_pkg
module lms_scan_checker
  import lms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_cmd_t     in_cmd,
  input  logic        out_strobe,
  input  out_res_t    out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          n_errors,
  output int          n_pending,
  output int          n_rows
);

  // register copies
  logic [15:0] divider;
  logic [3:0]  light_on, light_off, dark_on, dark_off;

  // scan state
  logic [15:0] pix_rows [8];
  logic [3:0]  scan_row;
  logic [7:0]  anode;
  logic [3:0]  light_ph, dark_ph;
  logic [15:0] tick_cnt;

  out_res_t rows_due [$];
  out_res_t want;
  int       err_cnt;
  int       row_cnt;

  assign n_errors = err_cnt;
  assign n_rows   = row_cnt;

  function automatic logic [3:0] phase_step(input logic [3:0] ph, on, off);
    logic [4:0] span;
    logic [3:0] nxt;
    span = {1'b0, on} + {1'b0, off};
    if (span > 5'd15) span = 5'd15;
    nxt = ph + 4'd1;
    // a zero period only matches at the roll-over to zero, so the counter just rolls over
    if (nxt == span[3:0]) nxt = 4'd0;
    return nxt;
  endfunction

  function automatic logic col_lit(input logic [1:0] code);
    logic lit;
    lit = 1'b0;
    case (code)
      LVL_FULL:  lit = 1'b1;
      LVL_LIGHT: lit = light_ph < light_on;
      LVL_DARK:  lit = dark_ph < dark_on;
      default:   lit = 1'b0;
    endcase
    return lit;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_DIVIDER:   divider   = data[15:0];
      REG_LIGHT_ON:  light_on  = data[3:0];
      REG_LIGHT_OFF: light_off = data[3:0];
      REG_DARK_ON:   dark_on   = data[3:0];
      REG_DARK_OFF:  dark_off  = data[3:0];
      default: ;
    endcase
  endtask

  task automatic take_beat(input in_cmd_t b);
    logic [4:0]  sh;
    logic [15:0] line;
    out_res_t    r;
    if (b.command == CMD_WRITE) begin
      // column 0 sits in the top bit pair
      sh = 5'd2 * (5'd7 - {2'b00, b.column});
      pix_rows[b.row] = (pix_rows[b.row] & ~(16'h3 << sh)) | ({14'd0, b.colour} << sh);
      return;
    end
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt < divider) return;
    tick_cnt = '0;
    if (scan_row >= 4'd8) begin
      light_ph = phase_step(light_ph, light_on, light_off);
      dark_ph  = phase_step(dark_ph, dark_on, dark_off);
      scan_row = '0;
      anode    = ANODE_FIRST;
    end
    line = pix_rows[scan_row[2:0]];
    for (int c = 0; c < 8; c++)
      r.cathode_bits[c] = col_lit(line[2*(7-c) +: 2]);
    r.row_index    = scan_row[2:0];
    r.anode_select = anode;
    rows_due.push_back(r);
    anode    = anode >> 1;
    scan_row = scan_row + 4'd1;
  endtask

  task automatic flag(input string what, input out_res_t exp, input out_res_t got);
    if (err_cnt < 10)
      $display({"%0t %s: expected row %0d anode %02h cathode %02h,",
                " got row %0d anode %02h cathode %02h"},
               $realtime, what, exp.row_index, exp.anode_select, exp.cathode_bits,
               got.row_index, got.anode_select, got.cathode_bits);
    err_cnt++;
  endtask

  initial begin
    err_cnt = 0;
    row_cnt = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      divider   = RST_DIVIDER;
      light_on  = RST_LIGHT_ON;
      light_off = RST_LIGHT_OFF;
      dark_on   = RST_DARK_ON;
      dark_off  = RST_DARK_OFF;
      for (int i = 0; i < 8; i++) pix_rows[i] = '0;
      scan_row  = 4'd8;
      anode     = ANODE_FIRST;
      light_ph  = '0;
      dark_ph   = '0;
      tick_cnt  = '0;
      rows_due.delete();
    end else begin
      if (out_strobe === 1'b1) begin
        if (rows_due.size() == 0) begin
          flag("row beat with nothing due", '0, out_res);
        end else begin
          want = rows_due.pop_front();
          if (out_res.row_index !== want.row_index ||
              out_res.anode_select !== want.anode_select ||
              out_res.cathode_bits !== want.cathode_bits)
            flag("row beat mismatch", want, out_res);
          row_cnt++;
        end
      end else if (out_strobe !== 1'b0) begin
        flag("unknown strobe", '0, out_res);
      end
      if (psel && penable && pwrite && pready) write_reg(paddr[4:2], pwdata);
      if (start && !busy) take_beat(in_cmd);
    end
    n_pending <= rows_due.size();
  end

endmodule

### tb/tb_led_matrix_grayscale_scanner.sv
// testbench top for led_matrix_grayscale_scanner: drives pixel writes, refresh ticks and
// register writes over several level and divider settings; lms_scan_checker judges rows
// depends on lms_pkg, led_matrix_grayscale_scanner and lms_scan_checker
module tb_led_matrix_grayscale_scanner;
  import lms_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_cmd_t     in_cmd;
  logic        out_strobe;
  out_res_t    out_res;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int n_errors, n_pending, n_rows;
  int n_writes, n_ticks, n_cfg;

  led_matrix_grayscale_scanner i_dut (
    .clk, .rst_n, .start, .busy, .in_cmd, .out_strobe, .out_res,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lms_scan_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_cmd, .out_strobe, .out_res,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .n_errors, .n_pending, .n_rows
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic in_cmd_t mk_beat(input logic cmd, input logic [2:0] col,
                                      input logic [2:0] row, input logic [1:0] lvl);
    in_cmd_t b;
    b.command = cmd;
    b.column  = col;
    b.row     = row;
    b.colour  = lvl;
    return b;
  endfunction

  function automatic in_cmd_t rand_beat(input int tick_pct);
    in_cmd_t b;
    {b.column, b.row, b.colour} = 8'($urandom_range(255));
    b.command = ($urandom_range(99) < tick_pct) ? CMD_TICK : CMD_WRITE;
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send(input in_cmd_t b);
    start  <= 1'b1;
    in_cmd <= b;
    do @(posedge clk); while (busy);
    if (b.command == CMD_TICK) n_ticks++;
    else n_writes++;
    @(negedge clk);
  endtask

  task automatic idle_gap(input bit quiet);
    int r, gap;
    r = $urandom_range(99);
    if (quiet || r < 60) gap = 0;
    else if (r < 93) gap = $urandom_range(3, 1);
    else gap = $urandom_range(40, 10);
    if (gap > 0) begin
      start  <= 1'b0;
      in_cmd <= rand_beat(50);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_cfg++;
  endtask

  task automatic set_levels(input logic [3:0] lon, loff, don, doff);
    set_reg(REG_LIGHT_ON, {28'd0, lon});
    set_reg(REG_LIGHT_OFF, {28'd0, loff});
    set_reg(REG_DARK_ON, {28'd0, don});
    set_reg(REG_DARK_OFF, {28'd0, doff});
  endtask

  // wait for the last row beat, then let the store access settle
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (n_pending != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (6) @(negedge clk);
  endtask

  task automatic run_random(input int n, input int tick_pct);
    bit quiet;
    quiet = ($urandom_range(3) == 0);
    repeat (n) begin
      send(rand_beat(tick_pct));
      idle_gap(quiet);
    end
  endtask

  initial begin
    int fails;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_cmd  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    n_writes = 0;
    n_ticks  = 0;
    n_cfg    = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: every level at the corner columns and rows, one overwrite to off,
    // then two frames of rows at the reset divider so the scan wraps twice
    send(mk_beat(CMD_WRITE, 3'd0, 3'd0, LVL_FULL));
    send(mk_beat(CMD_WRITE, 3'd7, 3'd0, LVL_LIGHT));
    send(mk_beat(CMD_WRITE, 3'd3, 3'd0, LVL_DARK));
    send(mk_beat(CMD_WRITE, 3'd1, 3'd0, LVL_FULL));
    send(mk_beat(CMD_WRITE, 3'd1, 3'd0, LVL_OFF));
    send(mk_beat(CMD_WRITE, 3'd7, 3'd7, LVL_FULL));
    send(mk_beat(CMD_WRITE, 3'd0, 3'd7, LVL_LIGHT));
    send(mk_beat(CMD_WRITE, 3'd6, 3'd1, LVL_DARK));
    repeat (16) send(mk_beat(CMD_TICK, 3'd7, 3'd7, LVL_FULL));
    drain();

    // divider 0 fires on every tick; light period saturates, dark period is zero
    set_reg(REG_DIVIDER, 32'd0);
    set_levels(4'd15, 4'd15, 4'd0, 4'd0);
    run_random(70, 75);
    drain();

    set_reg(REG_DIVIDER, 32'd1);
    set_levels(4'd0, 4'd0, 4'd15, 4'd15);
    run_random(70, 70);
    drain();

    set_reg(REG_DIVIDER, 32'd2);
    set_levels(4'd15, 4'd0, 4'd0, 4'd15);
    run_random(70, 70);
    drain();

    // largest divider: ticks pile up with no row, then a small divider fires at once
    set_reg(REG_DIVIDER, 32'd65535);
    set_levels(4'($urandom_range(15)), 4'($urandom_range(15)),
               4'($urandom_range(15)), 4'($urandom_range(15)));
    repeat (40) send(rand_beat(100));
    drain();
    set_reg(REG_DIVIDER, 32'd3);
    run_random(70, 70);
    drain();

    repeat (3) begin
      set_reg(REG_DIVIDER, 32'($urandom_range(4, 1)));
      set_levels(4'($urandom_range(15)), 4'($urandom_range(15)),
                 4'($urandom_range(15)), 4'($urandom_range(15)));
      run_random(70, 70);
      drain();
    end

    fails = n_errors + n_pending;
    $display("covered %0d pixel writes and %0d ticks under %0d register writes",
             n_writes, n_ticks, n_cfg);
    $display("%0d row beats compared, %0d errors, %0d rows never seen",
             n_rows, n_errors, n_pending);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
